// ===== rtl/caf_pkg.sv =====
// Shared types, codes and constants of the contiguous fit allocator.
package caf_pkg;

  localparam int unsigned ADDR_BITS    = 20;
  localparam int unsigned SIZE_BITS    = ADDR_BITS + 1;
  localparam int unsigned OWNER_BITS   = 8;
  localparam int unsigned MAX_SEG_DEF  = 16;
  localparam logic [SIZE_BITS-1:0] TOTAL_RESET = SIZE_BITS'(1) << ADDR_BITS;

  // Command codes.
  localparam logic [1:0] CMD_REQUEST = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  // Fit modes.
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_BAD   = 2'd3;

  // Status codes.
  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_NOOWNER = 3'd2;
  localparam logic [2:0] ST_BAD     = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [OWNER_BITS-1:0] owner_id;
    logic [SIZE_BITS-1:0]  request_size;
    logic [1:0]            fit_mode;
  } req_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [ADDR_BITS-1:0] block_start;
    logic [SIZE_BITS-1:0] free_total;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0]  start;
    logic [SIZE_BITS-1:0]  size;
    logic [OWNER_BITS-1:0] owner;
    logic                  used;
  } seg_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD_A,
    CELL_LOAD_B,
    CELL_FROM_PREV,
    CELL_FROM_NEXT
  } cell_op_e;

  typedef struct packed {
    cell_op_e             op;
    logic [SIZE_BITS-1:0] need;
  } cell_ctrl_t;

endpackage

// ===== rtl/caf_cell.sv =====
// One segment cell: holds a segment, shifts with its neighbors, checks fit.
module caf_cell
  import caf_pkg::*;
#(
  parameter logic [SIZE_BITS-1:0] RESET_SIZE = '0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  seg_t       load_a_i,
  input  seg_t       load_b_i,
  input  seg_t       prev_i,
  input  seg_t       next_i,
  output seg_t       seg_o,
  output logic       fit_o
);

  seg_t seg_q, seg_d;

  // Select the new content of the cell.
  always_comb begin
    case (ctrl_i.op)
      CELL_LOAD_A:    seg_d = load_a_i;
      CELL_LOAD_B:    seg_d = load_b_i;
      CELL_FROM_PREV: seg_d = prev_i;
      CELL_FROM_NEXT: seg_d = next_i;
      default:        seg_d = seg_q;
    endcase
  end

  // The whole segment resets; only the first cell starts with a size.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= '{start: '0, size: RESET_SIZE, owner: '0, used: 1'b0};
    end else begin
      seg_q <= seg_d;
    end
  end

  // A free segment fits when it is at least as large as the request.
  assign fit_o = !seg_q.used && (seg_q.size >= ctrl_i.need);
  assign seg_o = seg_q;

endmodule

// ===== rtl/contiguous_fit_allocator.sv =====
// Top level of the contiguous fit allocator: sequencer around a chain of segment cells.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_ready_o  | in_data_i (req_t)
//   out     | output    | out_valid_o/out_ready_i| out_data_o (rsp_t)
//   cfg     | input     | APB psel/penable/pready| total_size at byte address 0
//
// A request scans the live cells one a cycle, then places the block in the place state
// and reports from the final state. A release scans the live cells the same way, then
// merges one pair or steps one cell a cycle until no pair is left, and reports.
// A clear loads one free hole and reports. Reset gives one free hole of 2^20 units at once.
// A new transaction is taken while a result waits; a stalled output holds the
// block in its final state.
module contiguous_fit_allocator
  import caf_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = MAX_SEG_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = IW + 1;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_PLACE, S_REL_SCAN, S_MERGE, S_FINISH
  } state_e;

  state_e               state_q;
  req_t                 req_q;
  logic [IW-1:0]        idx_q;
  logic [IW-1:0]        pick_q;
  logic [SIZE_BITS-1:0] pick_size_q;
  logic                 found_q;
  logic                 hit_q;
  logic [2:0]           status_q;
  logic [ADDR_BITS-1:0] start_q;
  logic [SIZE_BITS-1:0] free_q;
  logic [CW-1:0]        count_q;
  logic [SIZE_BITS-1:0] total_q;
  logic                 out_valid_q;
  rsp_t                 out_q;

  seg_t       cell_seg [MAX_SEGMENTS];
  logic       cell_fit [MAX_SEGMENTS];
  cell_ctrl_t cell_ctrl [MAX_SEGMENTS];
  seg_t       load_a, load_b;

  // Configuration port.
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == 1'b0) ? 32'(total_q) : 32'd0;

  // Clear size saturated to the range from 1 to 2^ADDR_BITS.
  logic [SIZE_BITS-1:0] clear_size;
  always_comb begin
    if (total_q == '0) clear_size = SIZE_BITS'(1);
    else if (total_q > TOTAL_RESET) clear_size = TOTAL_RESET;
    else clear_size = total_q;
  end

  // Cell reads at the scan index and its neighbor.
  logic [IW-1:0]        idx_nx;
  logic [CW-1:0]        idx_w, pick_w;
  logic                 idx_last, pair_ok;
  seg_t                 cur, nxt;
  logic                 cur_fit;
  logic [SIZE_BITS-1:0] rest;
  logic                 in_acc, bad_req;

  assign idx_nx   = idx_q + IW'(1);
  assign idx_w    = CW'(idx_q);
  assign pick_w   = CW'(pick_q);
  assign idx_last = (idx_w == count_q - CW'(1));
  assign pair_ok  = (idx_w + CW'(1)) < count_q;
  assign cur      = cell_seg[idx_q];
  assign cur_fit  = cell_fit[idx_q];
  assign nxt      = cell_seg[idx_nx];
  assign rest     = pick_size_q - req_q.request_size;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc   = in_valid_i && in_ready_o;
  assign bad_req  = (in_data_i.cmd == CMD_REQUEST &&
                     (in_data_i.request_size == '0 || in_data_i.fit_mode == FIT_BAD)) ||
                    (in_data_i.cmd != CMD_REQUEST && in_data_i.cmd != CMD_RELEASE &&
                     in_data_i.cmd != CMD_CLEAR);

  // Per-cell commands and load data for the current step.
  always_comb begin
    load_a = cur;
    load_b = cur;
    for (int k = 0; k < MAX_SEGMENTS; k++) begin
      cell_ctrl[k].op   = CELL_HOLD;
      cell_ctrl[k].need = req_q.request_size;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && !bad_req && in_data_i.cmd == CMD_CLEAR) begin
          load_a = '{start: '0, size: clear_size, owner: '0, used: 1'b0};
          cell_ctrl[0].op = CELL_LOAD_A;
        end
      end
      S_PLACE: begin
        load_a = cell_seg[pick_q];
        load_a.size  = req_q.request_size;
        load_a.owner = req_q.owner_id;
        load_a.used  = 1'b1;
        load_b = '{start: cell_seg[pick_q].start + req_q.request_size[ADDR_BITS-1:0],
                   size: rest, owner: '0, used: 1'b0};
        if (found_q && !(rest != '0 && count_q == CNT_MAX)) begin
          for (int k = 0; k < MAX_SEGMENTS; k++) begin
            if (CW'(k) == pick_w) cell_ctrl[k].op = CELL_LOAD_A;
            else if (rest != '0 && CW'(k) == pick_w + CW'(1)) cell_ctrl[k].op = CELL_LOAD_B;
            else if (rest != '0 && CW'(k) > pick_w + CW'(1) && CW'(k) <= count_q)
              cell_ctrl[k].op = CELL_FROM_PREV;
          end
        end
      end
      S_REL_SCAN: begin
        load_a.used = 1'b0;
        if (cur.used && cur.owner == req_q.owner_id) cell_ctrl[idx_q].op = CELL_LOAD_A;
      end
      S_MERGE: begin
        load_a.size = cur.size + nxt.size;
        if (pair_ok && !cur.used && !nxt.used) begin
          for (int k = 0; k < MAX_SEGMENTS; k++) begin
            if (CW'(k) == idx_w) cell_ctrl[k].op = CELL_LOAD_A;
            else if (CW'(k) > idx_w && CW'(k) < count_q - CW'(1))
              cell_ctrl[k].op = CELL_FROM_NEXT;
          end
        end
      end
      default: ;
    endcase
  end

  // The chain of cells; each sees its two neighbors.
  for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
    seg_t prev_s, next_s;
    if (g == 0) begin : g_first
      assign prev_s = '0;
    end else begin : g_mid
      assign prev_s = cell_seg[g-1];
    end
    if (g == MAX_SEGMENTS - 1) begin : g_last
      assign next_s = '0;
    end else begin : g_body
      assign next_s = cell_seg[g+1];
    end
    caf_cell #(
      .RESET_SIZE((g == 0) ? TOTAL_RESET : '0)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl[g]),
      .load_a_i (load_a),
      .load_b_i (load_b),
      .prev_i   (prev_s),
      .next_i   (next_s),
      .seg_o    (cell_seg[g]),
      .fit_o    (cell_fit[g])
    );
  end

  // Sequencer with its registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      idx_q       <= '0;
      pick_q      <= '0;
      pick_size_q <= '0;
      found_q     <= 1'b0;
      hit_q       <= 1'b0;
      status_q    <= ST_DONE;
      start_q     <= '0;
      free_q      <= TOTAL_RESET;
      count_q     <= CW'(1);
      total_q     <= TOTAL_RESET;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_wr && paddr[2] == 1'b0) total_q <= pwdata[SIZE_BITS-1:0];
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            req_q   <= in_data_i;
            idx_q   <= '0;
            found_q <= 1'b0;
            hit_q   <= 1'b0;
            start_q <= '0;
            if (bad_req) begin
              status_q <= ST_BAD;
              state_q  <= S_FINISH;
            end else if (in_data_i.cmd == CMD_CLEAR) begin
              count_q  <= CW'(1);
              free_q   <= clear_size;
              status_q <= ST_DONE;
              state_q  <= S_FINISH;
            end else if (in_data_i.cmd == CMD_RELEASE) begin
              state_q <= S_REL_SCAN;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // First fit keeps the first hit; best and worst keep the strict improvement.
          if (cur_fit && (!found_q ||
              (req_q.fit_mode == FIT_BEST && cur.size < pick_size_q) ||
              (req_q.fit_mode == FIT_WORST && cur.size > pick_size_q))) begin
            found_q     <= 1'b1;
            pick_q      <= idx_q;
            pick_size_q <= cur.size;
          end
          idx_q <= idx_nx;
          if (idx_last) state_q <= S_PLACE;
        end
        S_PLACE: begin
          state_q <= S_FINISH;
          if (!found_q) begin
            status_q <= ST_NOFIT;
          end else if (rest != '0 && count_q == CNT_MAX) begin
            status_q <= ST_FULL;
          end else begin
            status_q <= ST_DONE;
            start_q  <= cell_seg[pick_q].start;
            free_q   <= free_q - req_q.request_size;
            if (rest != '0) count_q <= count_q + CW'(1);
          end
        end
        S_REL_SCAN: begin
          if (cur.used && cur.owner == req_q.owner_id) begin
            free_q <= free_q + cur.size;
            hit_q  <= 1'b1;
          end
          idx_q <= idx_nx;
          if (idx_last) begin
            idx_q <= '0;
            if (!hit_q && !(cur.used && cur.owner == req_q.owner_id)) begin
              status_q <= ST_NOOWNER;
              state_q  <= S_FINISH;
            end else begin
              state_q <= S_MERGE;
            end
          end
        end
        S_MERGE: begin
          if (!pair_ok) begin
            status_q <= ST_DONE;
            state_q  <= S_FINISH;
          end else if (!cur.used && !nxt.used) begin
            count_q <= count_q - CW'(1);
          end else begin
            idx_q <= idx_nx;
          end
        end
        S_FINISH: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q       <= 1'b1;
            out_q.status      <= status_q;
            out_q.block_start <= (status_q == ST_DONE) ? start_q : '0;
            out_q.free_total  <= free_q;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The table always holds at least one and at most all segments.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= CW'(1) && count_q <= CNT_MAX)
    else $error("segment count out of range");

  // Free units never exceed the largest managed memory.
  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= TOTAL_RESET)
    else $error("free total out of range");

  // A result appears only out of the final state.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FINISH)
    else $error("result raised outside the final state");

endmodule

// ===== tb/sv/tb_contiguous_fit_allocator.sv =====
// Testbench of the contiguous fit allocator: directed table, random traffic and a predictor.
module tb_contiguous_fit_allocator;
  import caf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSEG = MAX_SEG_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam logic [2:0] ADDR_TOTAL_SIZE = 3'd0;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  contiguous_fit_allocator dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk_i = ~clk_i;

  // Predicted copy of the segment table.
  seg_t tbl[NSEG];
  int unsigned tbl_count;
  logic [SIZE_BITS-1:0] tbl_free;
  logic [SIZE_BITS-1:0] cfg_total;

  rsp_t expected_rsp_q[$];
  int unsigned mismatches = 0;
  int unsigned rsp_seen = 0;
  int unsigned sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned n_req_ok = 0;
  int unsigned n_full = 0;
  int unsigned n_nofit = 0;

  // Rebuild the table as a single free hole of the configured size.
  function automatic void table_clear();
    logic [SIZE_BITS-1:0] sz;
    sz = cfg_total;
    if (sz == 0) sz = 1;
    if (sz > TOTAL_RESET) sz = TOTAL_RESET;
    for (int i = 0; i < NSEG; i++) tbl[i] = '0;
    tbl[0].size = sz;
    tbl_count = 1;
    tbl_free = sz;
  endfunction

  // Place a request by the given fit rule; returns the status and the start address.
  function automatic logic [2:0] table_request(logic [7:0] own, logic [SIZE_BITS-1:0] need,
                                               logic [1:0] mode,
                                               output logic [ADDR_BITS-1:0] at);
    int pick;
    logic [SIZE_BITS-1:0] rest;
    pick = -1;
    at = '0;
    if (need == 0 || mode == FIT_BAD) return ST_BAD;
    for (int i = 0; i < tbl_count; i++) begin
      if (!tbl[i].used && tbl[i].size >= need) begin
        if (pick < 0) begin
          pick = i;
          if (mode == FIT_FIRST) break;
        end else if (mode == FIT_BEST && tbl[i].size < tbl[pick].size) begin
          pick = i;
        end else if (mode == FIT_WORST && tbl[i].size > tbl[pick].size) begin
          pick = i;
        end
      end
    end
    if (pick < 0) return ST_NOFIT;
    rest = tbl[pick].size - need;
    if (rest != 0) begin
      if (tbl_count >= NSEG) return ST_FULL;
      for (int k = tbl_count; k > pick + 1; k--) tbl[k] = tbl[k-1];
      tbl[pick+1].start = tbl[pick].start + need;
      tbl[pick+1].size = rest;
      tbl[pick+1].owner = '0;
      tbl[pick+1].used = 1'b0;
      tbl_count++;
    end
    tbl[pick].size = need;
    tbl[pick].owner = own;
    tbl[pick].used = 1'b1;
    tbl_free -= need;
    at = tbl[pick].start;
    return ST_DONE;
  endfunction

  // Free every segment of one owner and merge neighboring holes.
  function automatic logic [2:0] table_release(logic [7:0] own);
    bit hit;
    int i;
    hit = 1'b0;
    for (i = 0; i < tbl_count; i++) begin
      if (tbl[i].used && tbl[i].owner == own) begin
        tbl[i].used = 1'b0;
        tbl_free += tbl[i].size;
        hit = 1'b1;
      end
    end
    if (!hit) return ST_NOOWNER;
    i = 0;
    while (i + 1 < tbl_count) begin
      if (!tbl[i].used && !tbl[i+1].used) begin
        tbl[i].size += tbl[i+1].size;
        for (int k = i + 1; k + 1 < tbl_count; k++) tbl[k] = tbl[k+1];
        tbl_count--;
      end else begin
        i++;
      end
    end
    return ST_DONE;
  endfunction

  function automatic rsp_t allocator_predict(req_t r);
    rsp_t o;
    logic [ADDR_BITS-1:0] at;
    at = '0;
    case (r.cmd)
      CMD_REQUEST: o.status = table_request(r.owner_id, r.request_size, r.fit_mode, at);
      CMD_RELEASE: o.status = table_release(r.owner_id);
      CMD_CLEAR: begin
        table_clear();
        o.status = ST_DONE;
      end
      default: o.status = ST_BAD;
    endcase
    if (o.status != ST_DONE) at = '0;
    o.block_start = at;
    o.free_total = tbl_free;
    return o;
  endfunction

  // Receiver side: random stall, checks every accepted result against the oldest expectation.
  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      rsp_seen++;
      if (expected_rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        e = expected_rsp_q.pop_front();
        if (out_data_o.status !== e.status || out_data_o.block_start !== e.block_start ||
            out_data_o.free_total !== e.free_total) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected st=%0d start=%0d free=%0d, %s",
                     e.status, e.block_start, e.free_total,
                     $sformatf("got st=%0d start=%0d free=%0d", out_data_o.status,
                               out_data_o.block_start, out_data_o.free_total));
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired: %0d results still expected", expected_rsp_q.size());
      $display("tb_contiguous_fit_allocator: FAIL");
      $finish;
    end
  end

  // Send one transaction, predicting its result when it is accepted.
  // Valid stays high after acceptance until the next call drops it or replaces the payload.
  task automatic send_item(req_t r);
    rsp_t e;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    e = allocator_predict(r);
    case (e.status)
      ST_DONE: if (r.cmd == CMD_REQUEST) n_req_ok++;
      ST_FULL: n_full++;
      ST_NOFIT: n_nofit++;
      default: ;
    endcase
    expected_rsp_q.push_back(e);
    sent++;
    @(negedge clk_i);
  endtask

  // Wait for every result and stay idle before touching the register.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_rsp_q.size() != 0) @(negedge clk_i);
    repeat (4 * NSEG + 8) @(negedge clk_i);
  endtask

  task automatic write_total(logic [31:0] v);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_TOTAL_SIZE; pwdata <= v; penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    cfg_total = v[SIZE_BITS-1:0];
  endtask

  function automatic req_t mk(logic [1:0] c, logic [7:0] o, logic [SIZE_BITS-1:0] s,
                              logic [1:0] m);
    req_t r;
    r.cmd = c; r.owner_id = o; r.request_size = s; r.fit_mode = m;
    return r;
  endfunction

  // Random item: mostly well-formed requests and releases of a few owners.
  function automatic req_t random_item(int unsigned scale);
    int unsigned p;
    logic [SIZE_BITS-1:0] s;
    p = $urandom_range(99);
    if (p < 3) return mk(CMD_CLEAR, 8'($urandom), 21'($urandom), 2'($urandom));
    if (p < 5) return mk(2'($urandom), 8'($urandom), 21'($urandom), 2'($urandom));
    if (p < 30) return mk(CMD_RELEASE, 8'($urandom_range(7)), 21'($urandom), 2'($urandom));
    if (p < 33) return mk(CMD_RELEASE, 8'($urandom), 21'($urandom), 2'($urandom));
    if (p < 38) s = 21'($urandom);
    else s = 21'($urandom_range(scale, 1));
    return mk(CMD_REQUEST, 8'($urandom_range(7)), s, 2'($urandom_range(2)));
  endfunction

  typedef struct {
    req_t req;
    bit typed;
    rsp_t rsp;
  } row_t;

  row_t dir_rows[$];

  task automatic add_row(req_t r, bit typed, logic [2:0] st,
                         logic [ADDR_BITS-1:0] at, logic [SIZE_BITS-1:0] fr);
    row_t w;
    w.req = r; w.typed = typed;
    w.rsp.status = st; w.rsp.block_start = at; w.rsp.free_total = fr;
    dir_rows.push_back(w);
  endtask

  initial begin
    rsp_t got;
    int unsigned scale;
    int unsigned phase_items;
    cfg_total = TOTAL_RESET;
    table_clear();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table; typed rows hold results read off at a glance.
    add_row(mk(CMD_REQUEST, 8'd1, 21'd0, FIT_FIRST), 1, ST_BAD, 0, TOTAL_RESET);
    add_row(mk(CMD_REQUEST, 8'd1, 21'd5, FIT_BAD), 1, ST_BAD, 0, TOTAL_RESET);
    add_row(mk(2'd3, 8'hFF, 21'h1FFFFF, FIT_BAD), 1, ST_BAD, 0, TOTAL_RESET);
    add_row(mk(CMD_RELEASE, 8'd9, 21'd0, FIT_FIRST), 1, ST_NOOWNER, 0, TOTAL_RESET);
    add_row(mk(CMD_REQUEST, 8'd1, 21'h1FFFFF, FIT_FIRST), 1, ST_NOFIT, 0, TOTAL_RESET);
    add_row(mk(CMD_REQUEST, 8'd1, TOTAL_RESET, FIT_BEST), 1, ST_DONE, 0, 0);
    add_row(mk(CMD_RELEASE, 8'd1, 21'd0, FIT_FIRST), 1, ST_DONE, 0, TOTAL_RESET);
    add_row(mk(CMD_REQUEST, 8'd0, 21'd1, FIT_FIRST), 0, 0, 0, 0);
    add_row(mk(CMD_REQUEST, 8'hFF, 21'd100, FIT_WORST), 0, 0, 0, 0);
    add_row(mk(CMD_REQUEST, 8'd2, 21'd10, FIT_BEST), 0, 0, 0, 0);
    add_row(mk(CMD_REQUEST, 8'd3, 21'd50, FIT_FIRST), 0, 0, 0, 0);
    add_row(mk(CMD_RELEASE, 8'hFF, 21'd0, FIT_FIRST), 0, 0, 0, 0);
    add_row(mk(CMD_REQUEST, 8'd4, 21'd20, FIT_BEST), 0, 0, 0, 0);
    add_row(mk(CMD_REQUEST, 8'd5, 21'd30, FIT_WORST), 0, 0, 0, 0);
    add_row(mk(CMD_RELEASE, 8'd2, 21'd0, FIT_FIRST), 0, 0, 0, 0);
    add_row(mk(CMD_RELEASE, 8'd0, 21'd0, FIT_FIRST), 0, 0, 0, 0);
    add_row(mk(CMD_CLEAR, 8'hFF, 21'h1FFFFF, FIT_BAD), 1, ST_DONE, 0, TOTAL_RESET);
    for (int i = 0; i < 17; i++) add_row(mk(CMD_REQUEST, 8'(i), 21'd1, FIT_FIRST), 0, 0, 0, 0);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].req);
      if (dir_rows[i].typed) begin
        got = expected_rsp_q[$];
        if (got != dir_rows[i].rsp) begin
          mismatches++;
          if (mismatches <= 10) $display("directed row %0d: typed result disagrees", i);
        end
      end
    end
    drain();

    // Random phases over six total sizes; the idling mix changes every two phases.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_total(32'd1);
        1: write_total(32'd0);
        2: write_total(32'h1FFFFF);
        3: write_total(32'd64);
        4: write_total(32'd1000);
        default: write_total(32'(TOTAL_RESET));
      endcase
      send_idle_pct = (ph < 2) ? 16 : (ph < 4) ? 66 : 0;
      recv_idle_pct = (ph < 2) ? 66 : (ph < 4) ? 16 : 0;
      send_item(mk(CMD_CLEAR, 8'd0, 21'd0, FIT_FIRST));
      scale = (ph == 3) ? 8 : (ph == 4) ? 120 : (ph == 2) ? 200000 : 4;
      phase_items = (ph < 2) ? 60 : 370;
      for (int n = 0; n < phase_items; n++) send_item(random_item(scale));
      drain();
    end

    $display("Sent %0d transactions, checked %0d results over six total sizes.", sent, rsp_seen);
    $display("Allocations %0d, table full %0d, no fitting hole %0d.", n_req_ok, n_full, n_nofit);
    if (mismatches == 0 && expected_rsp_q.size() == 0) begin
      $display("tb_contiguous_fit_allocator: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_rsp_q.size());
      $display("tb_contiguous_fit_allocator: FAIL");
    end
    $finish;
  end

endmodule
